@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion helpers
// shared macros for the concurrent checks of the queue block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle property violated");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

@@ sv/fbsr_pkg.sv @@
// ---------------------------------------------------------------------------
// fbsr package
// operation and status codes, controller states and the result record
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbsr_pkg;

    localparam int unsigned DATA_W = 32;

    // capacity register after reset
    localparam logic [7:0] CAP_RESET = 8'd100;

    // register index carried by paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        KIND_ENQUEUE = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_SEARCH  = 3'd2,
        KIND_REMOVE  = 3'd3,
        KIND_CLEAR   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_EXEC = 3'd1,
        S_DEQ  = 3'd2,
        S_SRCH = 3'd3,
        S_RMV  = 3'd4
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [7:0]               entry_count;
        t_status                  status;
    } t_result;

endpackage

@@ sv/fbsr_ram.sv @@
// ---------------------------------------------------------------------------
// fbsr ram
// simple dual-port storage, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbsr_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/fbsr_ctrl.sv @@
// ---------------------------------------------------------------------------
// fbsr controller
// sequencer that runs each queue operation over the storage ram
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbsr_ctrl #(
    parameter int DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_kind,
    input  logic signed [31:0]     i_item_value,
    input  logic [6:0]             i_position,
    input  logic [7:0]             i_capacity_limit,
    input  logic                   i_out_free,
    output logic                   o_res_valid,
    output fbsr_pkg::t_result      o_res
);

    import fbsr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 8) ? CW : 8;

    // (base + off) mod DEPTH, valid while the sum stays below twice the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(off);
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    t_state                r_state, n_state;
    logic [2:0]            r_kind;
    logic signed [31:0]    r_item;
    logic [6:0]            r_pos;
    logic [AW-1:0]         r_oldest, n_oldest;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_wptr, n_wptr;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_dv, n_dv;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [31:0]           ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [31:0]           ram_rdata;

    logic [WW-1:0]         lim_w;
    logic                  is_full;
    logic                  pos_bad;
    logic [CW-1:0]         victim;
    logic [AW-1:0]         victim_slot;
    logic                  hit;
    logic                  accept;

    assign accept  = i_in_valid && o_in_ready;
    assign lim_w   = (WW'(i_capacity_limit) > WW'(DEPTH)) ? WW'(DEPTH)
                                                          : WW'(i_capacity_limit);
    assign is_full = WW'(r_count) >= lim_w;
    assign pos_bad = WW'(r_pos) >= WW'(r_count);
    assign victim  = r_count - CW'(1) - CW'(r_pos);
    assign victim_slot = wrap_add(r_oldest, victim);
    assign hit     = ($signed(ram_rdata) == r_item);

    fbsr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (32)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_ptr    <= '0;
            r_wptr   <= '0;
            r_left   <= '0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_wptr   <= n_wptr;
            r_left   <= n_left;
            r_dv     <= n_dv;
        end
    end

    // request fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_item <= i_item_value;
            r_pos  <= i_position;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_oldest   = r_oldest;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_wptr     = r_wptr;
        n_left     = r_left;
        n_dv       = r_dv;
        ram_we     = 1'b0;
        ram_waddr  = r_wptr;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = r_ptr;
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res.read_value = '0;
        o_res.found      = 1'b0;
        o_res.status     = ST_OK;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_kind)
                    KIND_ENQUEUE: begin
                        if (i_out_free) begin
                            o_res_valid = 1'b1;
                            n_state     = S_IDLE;
                            if (is_full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = wrap_add(r_oldest, r_count);
                                ram_wdata = r_item;
                                n_count   = r_count + CW'(1);
                            end
                        end
                    end
                    KIND_DEQUEUE: begin
                        if (r_count == '0) begin
                            if (i_out_free) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_oldest;
                            n_state   = S_DEQ;
                        end
                    end
                    KIND_SEARCH: begin
                        if (r_count == '0) begin
                            if (i_out_free) begin
                                o_res_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_oldest;
                            n_ptr     = inc_slot(r_oldest);
                            n_left    = r_count;
                            n_state   = S_SRCH;
                        end
                    end
                    KIND_REMOVE: begin
                        if (pos_bad) begin
                            if (i_out_free) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_RANGE;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            n_wptr  = victim_slot;
                            n_ptr   = inc_slot(victim_slot);
                            n_left  = CW'(r_pos);
                            n_dv    = 1'b0;
                            n_state = S_RMV;
                        end
                    end
                    KIND_CLEAR: begin
                        if (i_out_free) begin
                            n_count     = '0;
                            n_oldest    = '0;
                            o_res_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    default: begin
                        // unused codes leave the queue alone
                        if (i_out_free) begin
                            o_res_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end

            S_DEQ: begin
                if (i_out_free) begin
                    o_res_valid      = 1'b1;
                    o_res.read_value = $signed(ram_rdata);
                    n_oldest         = inc_slot(r_oldest);
                    n_count          = r_count - CW'(1);
                    n_state          = S_IDLE;
                end
            end

            S_SRCH: begin
                // r_left counts compares still due, the current one included
                if (hit || (r_left == CW'(1))) begin
                    if (i_out_free) begin
                        o_res_valid = 1'b1;
                        o_res.found = hit;
                        n_state     = S_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr;
                    n_ptr     = inc_slot(r_ptr);
                    n_left    = r_left - CW'(1);
                end
            end

            S_RMV: begin
                // read one slot ahead, write the data back one slot older
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wptr;
                    ram_wdata = ram_rdata;
                    n_wptr    = inc_slot(r_wptr);
                end
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr;
                    n_ptr     = inc_slot(r_ptr);
                    n_left    = r_left - CW'(1);
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (!r_dv && (r_left == '0)) begin
                    if (i_out_free) begin
                        o_res_valid = 1'b1;
                        n_count     = r_count - CW'(1);
                        n_state     = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.entry_count = 8'(n_count);
    end

    `ASSERT_HOLDS(a_res_slot_free, i_clk, i_rst_n, o_res_valid, i_out_free)
    `ASSERT_HOLDS(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    `ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))

endmodule

@@ sv/bounded_fifo_with_search_remove_unit.sv @@
// ---------------------------------------------------------------------------
// bounded fifo with search and remove
// queue of signed 32-bit values with search, positional removal and clear
// ---------------------------------------------------------------------------
// One transaction in gives one transaction out. Entries live in a single
// DEPTH-deep ram with one write and one read port, and that read port sets
// the pace: dequeue reads the oldest entry before it answers, search reads
// one entry per compare (it stops at the first match) and remove-at-position
// moves every newer entry one slot older, one per cycle, before it answers.
// Unused codes, clear, enqueue and the empty or out-of-range cases need no
// read. Results sit in an output register, so the next transaction is taken
// while the last result waits. Storage needs no initialisation after reset.
// The capacity register lives at byte address 0; the limit it sets is
// clipped at DEPTH.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_fifo_with_search_remove_unit #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // request transactions
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_item_value,
    input  logic [6:0]         i_position,

    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_read_value,
    output logic               o_found,
    output logic [7:0]         o_entry_count,
    output logic [1:0]         o_status,

    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import fbsr_pkg::*;

    logic [7:0] r_capacity_limit;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_free;
    logic       res_valid;
    t_result    res;

    // register port, zero wait states
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity_limit <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_capacity_limit <= pwdata[7:0];
        end
    end

    // reads beyond the register list return zero
    assign prdata = (paddr[2] == REG_CAPACITY) ? {24'd0, r_capacity_limit} : 32'd0;

    // result register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;

    fbsr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_item_value     (i_item_value),
        .i_position       (i_position),
        .i_capacity_limit (r_capacity_limit),
        .i_out_free       (out_free),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out.read_value;
    assign o_found       = r_out.found;
    assign o_entry_count = r_out.entry_count;
    assign o_status      = r_out.status;

    // one transaction in flight at a time
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

@@ dv/fbsr_result_checker.sv @@
// ---------------------------------------------------------------------------
// fbsr result checker
// watches the request, result and register ports of the bounded queue,
// keeps a shadow of the queue contents and compares every result transaction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbsr_result_checker
    import fbsr_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_item_value,
    input  logic [6:0]         i_position,

    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_read_value,
    input  logic               i_found,
    input  logic [7:0]         i_entry_count,
    input  logic [1:0]         i_status,

    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,

    output int                 o_fail_count,
    output int                 o_outstanding
);

    localparam logic [2:0] CAP_ADDR = 3'd0;

    // shadow of the queue
    logic [31:0] shadow_mem [DEPTH];
    logic [6:0]  head_slot;
    logic [7:0]  fill;
    logic [7:0]  limit_reg;

    t_result     pending_results [$];
    int          mismatches;

    assign o_fail_count = mismatches;

    function automatic logic [6:0] slot_of(input int logical);
        return head_slot + logical[6:0];
    endfunction

    function automatic t_result apply_request(input logic [2:0] kind,
                                              input logic [31:0] value,
                                              input logic [6:0] pos);
        t_result    res;
        logic [7:0] lim;
        int         victim;
        res        = '0;
        res.status = ST_OK;
        lim        = (limit_reg > DEPTH) ? 8'(DEPTH) : limit_reg;
        case (kind)
            KIND_ENQUEUE: begin
                if (fill >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_mem[slot_of(int'(fill))] = value;
                    fill = fill + 8'd1;
                end
            end
            KIND_DEQUEUE: begin
                if (fill == 8'd0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = shadow_mem[head_slot];
                    head_slot      = head_slot + 7'd1;
                    fill           = fill - 8'd1;
                end
            end
            KIND_SEARCH: begin
                for (int i = 0; i < int'(fill); i++) begin
                    if (shadow_mem[slot_of(i)] == value) begin
                        res.found = 1'b1;
                        break;
                    end
                end
            end
            KIND_REMOVE: begin
                if ({1'b0, pos} >= fill) begin
                    res.status = ST_RANGE;
                end else begin
                    // position counts from the newest, close the gap towards the oldest
                    victim = int'(fill) - 1 - int'(pos);
                    for (int i = victim; i + 1 < int'(fill); i++)
                        shadow_mem[slot_of(i)] = shadow_mem[slot_of(i + 1)];
                    fill = fill - 8'd1;
                end
            end
            KIND_CLEAR: begin
                fill      = 8'd0;
                head_slot = 7'd0;
            end
            default: ;
        endcase
        res.entry_count = fill;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches    = 0;
        o_outstanding = 0;
        fill          = 8'd0;
        head_slot     = 7'd0;
        limit_reg     = CAP_RESET;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            fill      = 8'd0;
            head_slot = 7'd0;
            limit_reg = CAP_RESET;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", {30'd0, i_status}, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_read_value !== want.read_value)
                        report_mismatch("read_value", i_read_value, want.read_value);
                    if (i_found !== want.found)
                        report_mismatch("found", 32'(i_found), 32'(want.found));
                    if (i_entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(i_entry_count),
                                        32'(want.entry_count));
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_request(i_kind, i_item_value, i_position));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == CAP_ADDR)
                limit_reg = i_pwdata[7:0];
        end
        o_outstanding <= pending_results.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ---------------------------------------------------------------------------
// bounded queue testbench
// directed corner cases then paced random traffic over several capacity
// settings; results are predicted and compared by the checker beside the block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import fbsr_pkg::*;

    localparam int         DEPTH             = 128;
    localparam logic [2:0] CAP_ADDR          = 3'd0;
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MID   = 3'd6;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
    localparam int         IDLE_GUARD        = 8;
    localparam int         DRAIN_GUARD       = DEPTH + 8;
    localparam int         HOLD_CYCLES       = 400;

    // capacity and length of each random phase, extremes included
    localparam logic [7:0] PHASE_CAP [0:6] = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd37, 8'd100, 8'd0};
    localparam int         PHASE_LEN [0:6] = '{380, 220, 150, 80, 260, 230, 220};

    logic               i_clk;
    logic               i_rst_n;

    logic               in_valid;
    logic               in_ready;
    logic [2:0]         kind;
    logic signed [31:0] item_value;
    logic [6:0]         position;

    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] read_value;
    logic               found;
    logic [7:0]         entry_count;
    logic [1:0]         status;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int                 fail_count;
    int                 outstanding;

    // sender pacing and a short history of enqueued values for search hits
    int                 burst_left;
    logic [31:0]        recent_values [16];
    int                 recent_idx;

    bounded_fifo_with_search_remove_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_item_value  (item_value),
        .i_position    (position),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_read_value  (read_value),
        .o_found       (found),
        .o_entry_count (entry_count),
        .o_status      (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fbsr_result_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (kind),
        .i_item_value  (item_value),
        .i_position    (position),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_read_value  (read_value),
        .i_found       (found),
        .i_entry_count (entry_count),
        .i_status      (status),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // present one request transaction and hold it until the block takes it
    task automatic send_request(input logic [2:0] k, input logic [31:0] v,
                                input logic [6:0] p);
        @(negedge i_clk);
        in_valid   <= 1'b1;
        kind       <= k;
        item_value <= v;
        position   <= p;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // send, then either carry on with the burst or open a gap
    task automatic issue(input logic [2:0] k, input logic [31:0] v, input logic [6:0] p);
        int gap;
        send_request(k, v, p);
        if (k == KIND_ENQUEUE) begin
            recent_values[recent_idx] = v;
            recent_idx = (recent_idx + 1) % 16;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // drop valid and wait until every result transaction has come back
    task automatic wait_idle(input int guard);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (guard) @(negedge i_clk);
    endtask

    // two-phase register write, only while the block is idle
    task automatic write_capacity(input logic [7:0] cap);
        wait_idle(IDLE_GUARD);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {24'($urandom), cap};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // extremes, small values for duplicates, and wide random values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // receiver: segments of steady, random, sparse or periodic ready, plus
    // a long hold-off now and then so the block backs up into its input
    initial begin
        int mode;
        int seg_len;
        int seg_count;
        out_ready = 1'b0;
        seg_count = 0;
        forever begin
            seg_count++;
            if (seg_count % 30 == 4) begin
                @(negedge i_clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                mode    = $urandom_range(0, 3);
                seg_len = $urandom_range(10, 150);
                for (int c = 0; c < seg_len; c++) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 7) == 0);
                        default: out_ready <= ((c / 7) % 2 == 0);
                    endcase
                end
            end
        end
    end

    // stimulus
    initial begin
        int          r;
        int          fill_left;
        bit          filling;
        logic [2:0]  k;
        logic [31:0] v;
        logic [6:0]  p;
        logic [7:0]  cap;

        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_ENQUEUE;
        item_value = '0;
        position   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = CAP_ADDR;
        pwdata     = '0;
        burst_left = 0;
        recent_idx = 0;
        foreach (recent_values[i]) recent_values[i] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: dequeue, search and removal all have nothing to act on
        issue(KIND_DEQUEUE, 32'd0, 7'd0);
        issue(KIND_SEARCH, 32'h1234_5678, 7'd0);
        issue(KIND_REMOVE, 32'd0, 7'd0);
        // five entries with the value extremes
        issue(KIND_ENQUEUE, 32'h8000_0000, 7'd0);
        issue(KIND_ENQUEUE, 32'h7fff_ffff, 7'd0);
        issue(KIND_ENQUEUE, 32'h0000_0000, 7'd0);
        issue(KIND_ENQUEUE, 32'hffff_ffff, 7'd0);
        issue(KIND_ENQUEUE, 32'h0000_0005, 7'd0);
        // search hit and miss
        issue(KIND_SEARCH, 32'hffff_ffff, 7'd0);
        issue(KIND_SEARCH, 32'd12345, 7'd0);
        // newest removed, top position out of range, then the oldest
        issue(KIND_REMOVE, 32'd0, 7'd0);
        issue(KIND_REMOVE, 32'd0, 7'd127);
        issue(KIND_REMOVE, 32'd0, 7'd3);
        issue(KIND_DEQUEUE, 32'd0, 7'd0);
        // unused codes change nothing
        issue(KIND_UNUSED_FIRST, 32'hdead_beef, 7'd1);
        issue(KIND_UNUSED_MID, 32'h0bad_cafe, 7'd2);
        issue(KIND_UNUSED_LAST, 32'hffff_ffff, 7'd127);
        // clear, then dequeue from the emptied queue
        issue(KIND_CLEAR, 32'd0, 7'd0);
        issue(KIND_DEQUEUE, 32'd0, 7'd0);

        // zero capacity refuses every enqueue
        write_capacity(8'd0);
        issue(KIND_ENQUEUE, 32'd77, 7'd0);
        // single entry capacity
        write_capacity(8'd1);
        issue(KIND_ENQUEUE, 32'd11, 7'd0);
        issue(KIND_ENQUEUE, 32'd22, 7'd0);
        issue(KIND_SEARCH, 32'd11, 7'd0);
        issue(KIND_DEQUEUE, 32'd0, 7'd0);
        issue(KIND_DEQUEUE, 32'd0, 7'd0);

        // random phases, alternating fill-heavy and drain-heavy stretches
        for (int ph = 0; ph < 7; ph++) begin
            cap = (ph == 6) ? 8'($urandom_range(2, 127)) : PHASE_CAP[ph];
            write_capacity(cap);
            filling   = 1'b1;
            fill_left = $urandom_range(40, 160);
            for (int n = 0; n < PHASE_LEN[ph]; n++) begin
                if (fill_left == 0) begin
                    filling   = !filling;
                    fill_left = filling ? $urandom_range(40, 160) : $urandom_range(20, 80);
                end
                fill_left--;
                r = $urandom_range(0, 99);
                if (filling) begin
                    if      (r < 70) k = KIND_ENQUEUE;
                    else if (r < 80) k = KIND_DEQUEUE;
                    else if (r < 88) k = KIND_SEARCH;
                    else if (r < 97) k = KIND_REMOVE;
                    else if (r < 98) k = KIND_CLEAR;
                    else             k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
                end else begin
                    if      (r < 20) k = KIND_ENQUEUE;
                    else if (r < 60) k = KIND_DEQUEUE;
                    else if (r < 75) k = KIND_SEARCH;
                    else if (r < 96) k = KIND_REMOVE;
                    else if (r < 97) k = KIND_CLEAR;
                    else             k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
                end
                // searches mostly aim at values recently stored
                if (k == KIND_SEARCH && $urandom_range(0, 9) < 6)
                    v = recent_values[$urandom_range(0, 15)];
                else
                    v = pick_value();
                r = $urandom_range(0, 9);
                if      (r < 5) p = 7'($urandom_range(0, 7));
                else if (r < 8) p = 7'($urandom);
                else            p = 7'($urandom_range(0, 31));
                issue(k, v, p);
            end
        end

        // drain, let the block settle, then give the verdict
        wait_idle(DRAIN_GUARD);
        if (fail_count == 0) begin
            $display("[bounded_fifo_with_search_remove_unit] OK");
        end else begin
            $display("[bounded_fifo_with_search_remove_unit] ERROR");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("[bounded_fifo_with_search_remove_unit] ERROR");
        $finish;
    end

endmodule
